@@ design/running_latency_statistics_unit_macros.svh @@
// assertion macros shared by the statistics unit modules
`ifndef RUNNING_LATENCY_STATISTICS_UNIT_MACROS_SVH
`define RUNNING_LATENCY_STATISTICS_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define RLS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rls assertion failed");

// next-cycle implication, disabled during reset
`define RLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rls assertion failed");

`else

`define RLS_ASSERT_IMPL(lbl, ante, cons)
`define RLS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ design/rls_pkg.sv @@
package rls_pkg;

    localparam int DUR_W     = 32;
    localparam int CNT_OUT_W = 32;
    localparam int MEAN_OUT_W = 48;
    localparam int SQ_W      = 64;
    localparam int OUT_W     = 3 * CNT_OUT_W + MEAN_OUT_W + SQ_W;

    // command codes as carried in the low tuser bit
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // decoupling queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // index of the step that adds the last partial product of the 64 x 64 multiply
    localparam logic [2:0] MUL_LAST = 3'd4;

    typedef enum logic {
        K_RECORD,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               clear;
        logic [DUR_W-1:0]   dur;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_stream;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_UPD,
        S_MUL,
        S_SQ
    } t_state;

endpackage

@@ design/rls_front.sv @@
module rls_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [rls_pkg::DUR_W-1:0]  i_s_tdata,
    input  logic [1:0]                 i_s_tuser,
    output rls_pkg::t_stream           o_push,
    input  logic                       i_push_ready
);
    import rls_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  dec_op;

    // decode the beat: clear only matters on a read
    always_comb begin
        dec_op.kind  = (i_s_tuser[0] == CMD_READ) ? K_READ : K_RECORD;
        dec_op.clear = (i_s_tuser[0] == CMD_READ) & i_s_tuser[1];
        dec_op.dur   = i_s_tdata;
    end

    assign o_s_tready = !r_valid || i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_op <= dec_op;
        end
    end

    assign o_push.valid = r_valid;
    assign o_push.op    = r_op;

endmodule

@@ design/rls_queue.sv @@
`include "running_latency_statistics_unit_macros.svh"

module rls_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rls_pkg::t_stream i_push,
    output logic             o_push_ready,
    output rls_pkg::t_stream o_head,
    input  logic             i_pop
);
    import rls_pkg::*;

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_fill;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_fill != QCNT_W'(QDEPTH));
    assign push         = i_push.valid && o_push_ready;
    assign pop          = i_pop && (r_fill != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.op;
        end
    end

    assign o_head.valid = (r_fill != '0);
    assign o_head.op    = r_mem[r_rd];

    `RLS_ASSERT_IMPL(a_fill_bound, 1'b1, r_fill <= QCNT_W'(QDEPTH))
    `RLS_ASSERT_NEXT(a_fill_up, push && !pop, r_fill == $past(r_fill) + 1'b1)
    `RLS_ASSERT_NEXT(a_fill_down, pop && !push, r_fill == $past(r_fill) - 1'b1)

endmodule

@@ design/rls_back.sv @@
`include "running_latency_statistics_unit_macros.svh"

module rls_back #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rls_pkg::t_stream           i_head,
    output logic                       o_pop,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [rls_pkg::OUT_W-1:0]  o_m_tdata
);
    import rls_pkg::*;

    localparam int MW  = 32 + FRAC_BITS;
    localparam int PW  = 2 * MW;
    localparam int DCW = $clog2(MW);

    t_state                r_state;
    t_state                n_state;

    logic [COUNT_BITS-1:0] r_count;
    logic [DUR_W-1:0]      r_min;
    logic [DUR_W-1:0]      r_max;
    logic [MW-1:0]         r_mean;
    logic [SQ_W-1:0]       r_sq;

    logic [MW-1:0]         r_x;
    logic                  r_neg;
    logic [MW-1:0]         r_mag;
    logic [MW-1:0]         r_dq;
    logic [COUNT_BITS-1:0] r_rem;
    logic [DCW-1:0]        r_dcnt;
    logic [MW-1:0]         r_d2;
    logic [2:0]            r_mk;
    logic [63:0]           r_pp;
    logic [1:0]            r_pp_sh;
    logic [PW-1:0]         r_acc;

    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic                  out_free;
    logic                  start_rec;
    logic                  load_out;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [MW-1:0]         x_new;
    logic                  x_lt;
    logic [MW-1:0]         mag_new;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  q_bit;
    logic [COUNT_BITS:0]   rem_next;
    logic [MW-1:0]         mean_new;
    logic [63:0]           op_a;
    logic [63:0]           op_b;
    logic [31:0]           chunk_a;
    logic [31:0]           chunk_b;
    logic [63:0]           pp_c;
    logic [127:0]          pp_wide;
    logic [127:0]          acc_wide;
    logic [127:0]          term_wide;
    logic [SQ_W:0]         sq_sum;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start_rec) n_state = S_DIV;
            S_DIV:  if (r_dcnt == '0) n_state = S_UPD;
            S_UPD:  n_state = S_MUL;
            S_MUL:  if (r_mk == MUL_LAST) n_state = S_SQ;
            S_SQ:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        out_free  = !r_out_valid || i_m_tready;
        o_pop     = 1'b0;
        start_rec = 1'b0;
        load_out  = 1'b0;
        if (r_state == S_IDLE && i_head.valid) begin
            if (i_head.op.kind == K_RECORD) begin
                o_pop     = 1'b1;
                start_rec = 1'b1;
            end else if (out_free) begin
                o_pop    = 1'b1;
                load_out = 1'b1;
            end
        end
    end

    // sample setup, divider step, mean update, multiply and sum datapath
    always_comb begin
        cnt_new  = (r_count == {COUNT_BITS{1'b1}}) ? r_count : r_count + 1'b1;
        x_new    = MW'(i_head.op.dur) << FRAC_BITS;
        x_lt     = x_new < r_mean;
        mag_new  = x_lt ? (r_mean - x_new) : (x_new - r_mean);

        rem_sh   = {r_rem, r_dq[MW-1]};
        q_bit    = rem_sh >= {1'b0, r_count};
        rem_next = q_bit ? (rem_sh - {1'b0, r_count}) : rem_sh;

        mean_new = r_neg ? (r_mean - r_dq) : (r_mean + r_dq);

        op_a     = 64'(r_mag);
        op_b     = 64'(r_d2);
        chunk_a  = r_mk[1] ? op_a[63:32] : op_a[31:0];
        chunk_b  = r_mk[0] ? op_b[63:32] : op_b[31:0];
        pp_c     = chunk_a * chunk_b;
        pp_wide  = {64'b0, r_pp} << {r_pp_sh, 5'b0};

        acc_wide  = 128'(r_acc);
        term_wide = acc_wide >> FRAC_BITS;
        sq_sum    = {1'b0, r_sq} + {1'b0, term_wide[SQ_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_mean      <= '0;
            r_sq        <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            if (load_out && i_head.op.clear) begin
                r_count <= '0;
                r_min   <= '1;
                r_max   <= '0;
                r_mean  <= '0;
                r_sq    <= '0;
            end

            if (start_rec) begin
                r_count <= cnt_new;
                if (i_head.op.dur < r_min) r_min <= i_head.op.dur;
                if (i_head.op.dur > r_max) r_max <= i_head.op.dur;
            end

            if (r_state == S_UPD) begin
                r_mean <= mean_new;
            end

            if (r_state == S_SQ) begin
                if ((|term_wide[127:SQ_W]) || sq_sum[SQ_W]) begin
                    r_sq <= '1;
                end else begin
                    r_sq <= sq_sum[SQ_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {r_sq, MEAN_OUT_W'(r_mean), r_max, r_min, CNT_OUT_W'(r_count)};
        end

        if (start_rec) begin
            r_x    <= x_new;
            r_neg  <= x_lt;
            r_mag  <= mag_new;
            r_dq   <= mag_new;
            r_rem  <= '0;
            r_dcnt <= DCW'(MW - 1);
        end

        // restoring division, one quotient bit a cycle
        if (r_state == S_DIV) begin
            r_rem  <= rem_next[COUNT_BITS-1:0];
            r_dq   <= {r_dq[MW-2:0], q_bit};
            r_dcnt <= r_dcnt - 1'b1;
        end

        if (r_state == S_UPD) begin
            r_d2  <= r_neg ? (mean_new - r_x) : (r_x - mean_new);
            r_acc <= '0;
            r_mk  <= '0;
        end

        // four 32 x 32 partial products, each registered and added in the next cycle
        if (r_state == S_MUL) begin
            r_mk    <= r_mk + 1'b1;
            r_pp    <= pp_c;
            r_pp_sh <= 2'(r_mk[1]) + 2'(r_mk[0]);
            if (r_mk != '0) begin
                r_acc <= r_acc + pp_wide[PW-1:0];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `RLS_ASSERT_IMPL(a_div_count_nonzero, r_state == S_DIV, r_count != '0)
    `RLS_ASSERT_IMPL(a_min_le_max, r_count != '0 && r_state == S_IDLE, r_min <= r_max)
    `RLS_ASSERT_IMPL(a_step_le_mag, r_state == S_UPD, r_dq <= r_mag)
    `RLS_ASSERT_NEXT(a_read_loads_out, load_out, r_out_valid)

endmodule

@@ design/running_latency_statistics_unit.sv @@
// Running latency statistics: every input beat is either a record (low tuser bit 0), which
// adds the duration in tdata to the count, minimum, maximum, running mean and running sum of
// squared deviations (Welford update, mean in Q32.FRAC_BITS, deviation sum in
// Q(64-FRAC_BITS).FRAC_BITS saturating at all ones, count saturating at its top), or a read
// (low tuser bit 1), which returns one output beat with all five statistics and, with tuser
// bit 1 set, clears them afterwards. Records give no output beat. A record occupies the back
// end through the bit-serial divider that produces one quotient bit of the mean step a
// cycle, followed by four 32 x 32 partial products for the squared term; a read is taken
// by the back end once the output register is free. Input beats are taken into a front
// register and a two-entry queue while the back end is busy, so the input side stalls only
// when both are full.

module running_latency_statistics_unit #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [rls_pkg::DUR_W-1:0]  i_s_tdata,   // duration_us
    input  logic [1:0]                 i_s_tuser,   // command, clear_after
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [rls_pkg::OUT_W-1:0]  o_m_tdata    // sample_count, min_us, max_us,
                                                    // mean_q16, sq_dev_sum_q16
);
    import rls_pkg::*;

    t_stream front_push;
    logic    push_ready;
    t_stream queue_head;
    logic    back_pop;

    // front: registers the beat and decodes record or read
    rls_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_push       (front_push),
        .i_push_ready (push_ready)
    );

    // short queue so the front keeps taking beats during a long record
    rls_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .o_push_ready (push_ready),
        .o_head       (queue_head),
        .i_pop        (back_pop)
    );

    // back: statistics registers, divider, multiplier and output register
    rls_back #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (queue_head),
        .o_pop      (back_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

@@ dv/tb_running_latency_statistics_unit.sv @@
module tb_running_latency_statistics_unit;

    localparam int FRAC       = 16;
    localparam int MEAN_W     = 32 + FRAC;
    localparam int CYCLE_CAP  = 600000;   // far above the slowest legal run
    localparam int DRAIN_WAIT = 250;      // front register + queue of records still to finish

    // one output beat, lowest field in the lowest bits
    typedef struct packed {
        logic [63:0] sq_dev;
        logic [47:0] mean;
        logic [31:0] max_us;
        logic [31:0] min_us;
        logic [31:0] count;
    } t_stats;

    // flavours of random durations
    typedef enum int {
        SPREAD_SMALL,
        SPREAD_CLUSTER,
        SPREAD_FULL,
        SPREAD_CORNER
    } t_spread;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [rls_pkg::DUR_W-1:0]     i_s_tdata  = '0;   // duration_us
    logic [1:0]                    i_s_tuser  = '0;   // command, clear_after
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [rls_pkg::OUT_W-1:0]     o_m_tdata;         // count, min, max, mean, sq dev sum

    // predicted statistics, updated as each beat is accepted
    logic [31:0]       count_q;
    logic [31:0]       min_q;
    logic [31:0]       max_q;
    logic [MEAN_W-1:0] mean_q;
    logic [63:0]       sq_dev_q;

    t_stats stats_due[$];
    t_stats seen_stats;
    t_stats due_stats;

    bit steady = 1'b0;   // no idling on either side while set
    int errors;
    int records_sent;
    int reads_sent;
    int clears_sent;
    int beats_checked;
    int cycles;

    running_latency_statistics_unit #(
        .FRAC_BITS  (FRAC),
        .COUNT_BITS (32)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d reads outstanding", cycles, stats_due.size());
            $display("running_latency_statistics_unit: mismatch");
            $finish;
        end
    end

    // output side back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 35);
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_stats();
        count_q  = '0;
        min_q    = '1;
        max_q    = '0;
        mean_q   = '0;
        sq_dev_q = '0;
    endfunction

    // welford update for one sample
    function automatic void fold_sample(logic [31:0] dur);
        logic [MEAN_W-1:0] x;
        logic [MEAN_W-1:0] mag;
        logic [MEAN_W-1:0] step;
        logic [MEAN_W-1:0] d2;
        logic [127:0]      prod;
        logic [64:0]       acc;
        x = {dur, {FRAC{1'b0}}};
        if (count_q != '1)
            count_q = count_q + 1;
        if (dur < min_q)
            min_q = dur;
        if (dur > max_q)
            max_q = dur;
        // delta divided by the new count, magnitude first so it truncates toward zero
        if (x >= mean_q) begin
            mag    = x - mean_q;
            step   = mag / MEAN_W'(count_q);
            mean_q = mean_q + step;
            d2     = x - mean_q;
        end else begin
            mag    = mean_q - x;
            step   = mag / MEAN_W'(count_q);
            mean_q = mean_q - step;
            d2     = mean_q - x;
        end
        // exact product at twice the fraction bits, back to FRAC, then saturating add
        prod = (128'(mag) * 128'(d2)) >> FRAC;
        if (prod[127:64] != '0) begin
            sq_dev_q = '1;
        end else begin
            acc      = {1'b0, sq_dev_q} + {1'b0, prod[63:0]};
            sq_dev_q = acc[64] ? '1 : acc[63:0];
        end
    endfunction

    function automatic t_stats snapshot_stats();
        t_stats s;
        s.count  = count_q;
        s.min_us = min_q;
        s.max_us = max_q;
        s.mean   = mean_q[47:0];
        s.sq_dev = sq_dev_q;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // input driver: one beat, random gaps before it unless steady
    // ------------------------------------------------------------------

    task automatic send_beat(input logic cmd, input logic clr, input logic [31:0] dur);
        while (!steady && $urandom_range(99) < 35) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= $urandom;
            i_s_tuser  <= 2'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= dur;
        i_s_tuser  <= {clr, cmd};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        // accepted: advance the prediction in beat order
        if (cmd == rls_pkg::CMD_READ) begin
            stats_due.push_back(snapshot_stats());
            reads_sent++;
            if (clr) begin
                clears_sent++;
                clear_stats();
            end
        end else begin
            fold_sample(dur);
            records_sent++;
        end
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // checker: every output beat against the oldest predicted read
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_stats = t_stats'(o_m_tdata);
            if (stats_due.size() == 0) begin
                errors++;
                $display("%0t unrequested beat: expected none, got %h", $time, o_m_tdata);
            end else begin
                due_stats = stats_due.pop_front();
                check_field("sample_count", 64'(due_stats.count), 64'(seen_stats.count));
                check_field("min_us", 64'(due_stats.min_us), 64'(seen_stats.min_us));
                check_field("max_us", 64'(due_stats.max_us), 64'(seen_stats.max_us));
                check_field("mean_q16", 64'(due_stats.mean), 64'(seen_stats.mean));
                check_field("sq_dev_sum_q16", due_stats.sq_dev, seen_stats.sq_dev);
                beats_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reads before any sample: reset values, clearing an empty set
    task automatic test_empty_reads();
        send_beat(rls_pkg::CMD_READ, 1'b0, 32'h0);
        send_beat(rls_pkg::CMD_READ, 1'b1, 32'hFFFF_FFFF);
        send_beat(rls_pkg::CMD_READ, 1'b0, 32'h1234_5678);
    endtask

    // full-scale jump drives the squared sum into saturation, then it must stay there
    task automatic test_corner_samples();
        send_beat(rls_pkg::CMD_RECORD, 1'b1, 32'hFFFF_FFFF);
        send_beat(rls_pkg::CMD_RECORD, 1'b0, 32'h0);
        send_beat(rls_pkg::CMD_READ,   1'b0, 32'h0);
        send_beat(rls_pkg::CMD_RECORD, 1'b1, 32'd5);
        send_beat(rls_pkg::CMD_READ,   1'b1, 32'h0);
    endtask

    // fractional mean, mean moving down, step truncated toward zero
    task automatic test_mean_steps();
        send_beat(rls_pkg::CMD_RECORD, 1'b0, 32'd1);
        send_beat(rls_pkg::CMD_RECORD, 1'b0, 32'd2);
        send_beat(rls_pkg::CMD_READ,   1'b0, 32'h0);
        send_beat(rls_pkg::CMD_RECORD, 1'b0, 32'd0);
        send_beat(rls_pkg::CMD_RECORD, 1'b0, 32'd7);
        send_beat(rls_pkg::CMD_READ,   1'b1, 32'h0);
        send_beat(rls_pkg::CMD_RECORD, 1'b0, 32'd10);
        send_beat(rls_pkg::CMD_RECORD, 1'b0, 32'd0);
        send_beat(rls_pkg::CMD_RECORD, 1'b0, 32'd0);
        send_beat(rls_pkg::CMD_READ,   1'b1, 32'h0);
    endtask

    // alternating bit patterns, clear flag set on records where it means nothing
    task automatic test_bit_patterns();
        send_beat(rls_pkg::CMD_RECORD, 1'b1, 32'hAAAA_AAAA);
        send_beat(rls_pkg::CMD_RECORD, 1'b1, 32'h5555_5555);
        send_beat(rls_pkg::CMD_READ,   1'b1, 32'hFFFF_FFFF);
    endtask

    function automatic logic [31:0] pick_duration(t_spread spread, logic [31:0] base);
        case (spread)
            SPREAD_SMALL:   return $urandom_range(2000);
            SPREAD_CLUSTER: return base + $urandom_range(255) - 32'd128;
            SPREAD_FULL:    return $urandom;
            default: begin
                case ($urandom_range(4))
                    0:       return 32'h0;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h1;
                    3:       return 32'h8000_0000;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // batches of samples closed by a read, with the odd stray read in between
    task automatic test_random_batches(input int n_items);
        int      sent;
        int      batch;
        t_spread spread;
        logic [31:0] base;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_beat(rls_pkg::CMD_READ, $urandom_range(3) == 0, $urandom);
                sent++;
            end else begin
                batch  = $urandom_range(1, 10);
                spread = t_spread'($urandom_range(3));
                base   = $urandom;
                repeat (batch) begin
                    send_beat(rls_pkg::CMD_RECORD, 1'($urandom), pick_duration(spread, base));
                    sent++;
                end
                send_beat(rls_pkg::CMD_READ, $urandom_range(99) < 40, $urandom);
                sent++;
            end
        end
    endtask

    // same traffic with both sides always ready
    task automatic test_back_to_back(input int n_items);
        steady = 1'b1;
        test_random_batches(n_items);
        steady = 1'b0;
    endtask

    initial begin
        clear_stats();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_reads();
        test_corner_samples();
        test_mean_steps();
        test_bit_patterns();
        test_random_batches(450);
        test_back_to_back(250);
        test_random_batches(280);

        i_s_tvalid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge i_clk);
        // trailing records give no beat; let them finish and catch any stray output
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d duration records and %0d statistics reads (%0d clearing)",
                 records_sent, reads_sent, clears_sent);
        $display("%0d output beats compared, %0d field errors", beats_checked, errors);
        if (errors == 0) begin
            $display("running_latency_statistics_unit: match");
        end else begin
            $display("running_latency_statistics_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/rls_pkg.sv
design/rls_front.sv
design/rls_queue.sv
design/rls_back.sv
design/running_latency_statistics_unit.sv
dv/tb_running_latency_statistics_unit.sv
